[design/short_code_packet_deframer_top_assert.svh]
// Assertion macros for the deframer; compiled out for synthesis.
`ifndef SHORT_CODE_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define SHORT_CODE_PACKET_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SCDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCDF_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCDF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/scdf_pkg.sv]
`default_nettype none

package scdf_pkg;

    localparam logic [7:0] TYPE_GET     = 8'h01;
    localparam logic [7:0] TYPE_COMMAND = 8'h02;
    localparam logic [7:0] TYPE_RAW     = 8'h03;

    localparam logic [1:0] KIND_GET     = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_RAW     = 2'd2;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LEN_LO  = 2'd1,
        PH_LEN_HI  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] argument;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

[design/scdf_in_buf.sv]
`default_nettype none

module scdf_in_buf
    import scdf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_byte,
    output logic            o_hd_valid,
    output logic [7:0]      o_hd_byte,
    input  wire logic       i_pop
);

    logic       r_hd_valid;
    logic [7:0] r_hd_byte;
    logic       r_sk_valid;
    logic [7:0] r_sk_byte;
    logic       accept;

    assign o_stall    = r_sk_valid;
    assign accept     = i_valid && !r_sk_valid;
    assign o_hd_valid = r_hd_valid;
    assign o_hd_byte  = r_hd_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (r_sk_valid) begin
            // drain skid into head
            if (i_pop) begin
                r_hd_valid <= 1'b1;
                r_sk_valid <= 1'b0;
            end
        end else if (accept && r_hd_valid && !i_pop) begin
            r_sk_valid <= 1'b1;
        end else if (accept) begin
            r_hd_valid <= 1'b1;
        end else if (i_pop) begin
            r_hd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (i_pop) begin
                r_hd_byte <= r_sk_byte;
            end
        end else if (accept && r_hd_valid && !i_pop) begin
            r_sk_byte <= i_byte;
        end else if (accept) begin
            r_hd_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

[design/scdf_parse.sv]
`default_nettype none

`include "short_code_packet_deframer_top_assert.svh"

module scdf_parse
    import scdf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_out_ready,
    output logic            o_advance,
    output logic            o_res_valid,
    output t_result         o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_decl, n_decl;
    logic [15:0] r_left, n_left;
    logic [15:0] hdr_len;
    logic        is_data_type;
    logic        final_byte;
    logic [1:0]  data_kind;

    assign hdr_len      = {i_byte, r_len_lo};
    assign is_data_type = (r_type == TYPE_COMMAND) || (r_type == TYPE_RAW);
    assign final_byte   = (r_left <= 16'd1);
    assign data_kind    = (r_type == TYPE_COMMAND) ? KIND_COMMAND : KIND_RAW;

    // next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_TYPE:    n_phase = PH_LEN_LO;
            PH_LEN_LO:  n_phase = PH_LEN_HI;
            PH_LEN_HI: begin
                if (is_data_type && hdr_len != 16'd0) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_TYPE;
                end
            end
            PH_PAYLOAD: begin
                if (final_byte) begin
                    n_phase = PH_TYPE;
                end
            end
            default:    n_phase = PH_TYPE;
        endcase
    end

    // outputs and header fields
    always_comb begin
        n_type      = r_type;
        n_len_lo    = r_len_lo;
        n_decl      = r_decl;
        n_left      = r_left;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_phase)
            PH_TYPE:   n_type   = i_byte;
            PH_LEN_LO: n_len_lo = i_byte;
            PH_LEN_HI: begin
                n_decl = hdr_len;
                if (r_type == TYPE_GET) begin
                    o_res_valid    = 1'b1;
                    o_res.kind     = KIND_GET;
                    o_res.argument = hdr_len;
                    o_res.last     = 1'b1;
                end else if (is_data_type) begin
                    if (hdr_len == 16'd0) begin
                        // empty packet: one last-marked result, no data
                        o_res_valid = 1'b1;
                        o_res.kind  = data_kind;
                        o_res.last  = 1'b1;
                    end else begin
                        n_left = hdr_len;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_res_valid          = 1'b1;
                o_res.kind           = data_kind;
                o_res.payload_length = r_decl;
                o_res.data_byte      = i_byte;
                o_res.has_data       = 1'b1;
                o_res.last           = final_byte;
                n_left               = final_byte ? 16'd0 : r_left - 16'd1;
            end
            default: ;
        endcase
    end

    // a byte with no result never waits on the output side
    assign o_advance = i_valid && (!o_res_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_type   <= '0;
            r_len_lo <= '0;
            r_decl   <= '0;
            r_left   <= '0;
        end else if (o_advance) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_len_lo <= n_len_lo;
            r_decl   <= n_decl;
            r_left   <= n_left;
        end
    end

    `SCDF_ASSERT(a_payload_left, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> (r_left != 16'd0), "payload phase with no bytes left")
    `SCDF_ASSERT(a_payload_type, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> is_data_type, "payload phase for a type without payload")
    `SCDF_ASSERT(a_left_le_decl, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> (r_left <= r_decl), "bytes left exceed declared length")
    `SCDF_ASSERT(a_last_closes, i_clk, i_rst_n, (o_advance && o_res_valid && o_res.last) |=> (r_phase == PH_TYPE), "last result did not return to header parsing")

endmodule

`default_nettype wire

[design/scdf_out_reg.sv]
`default_nettype none

module scdf_out_reg
    import scdf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

[design/short_code_packet_deframer_top.sv]
// An accepted byte waits in the input head or skid register; its result, if any, goes to the result register.
// Throughput: one byte per cycle unless the output stalls; the header parser updates its state once per byte.
// Input stall is driven from a registered skid stage, output from a result register.
// Reset (i_rst_n low, synchronous) empties both stages and returns the parser
// to expecting a type byte with all header fields cleared.
`default_nettype none

module short_code_packet_deframer_top
    import scdf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_argument,
    output logic [15:0]      o_payload_length,
    output logic [7:0]       o_data_byte,
    output logic             o_has_data,
    output logic             o_last
);

    logic       hd_valid;
    logic [7:0] hd_byte;
    logic       advance;
    logic       res_valid;
    logic       out_ready;
    t_result    res;
    t_result    out_res;

    scdf_in_buf u_in_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_byte     (i_in_byte),
        .o_hd_valid (hd_valid),
        .o_hd_byte  (hd_byte),
        .i_pop      (advance)
    );

    scdf_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (hd_valid),
        .i_byte      (hd_byte),
        .i_out_ready (out_ready),
        .o_advance   (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    scdf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_argument       = out_res.argument;
    assign o_payload_length = out_res.payload_length;
    assign o_data_byte      = out_res.data_byte;
    assign o_has_data       = out_res.has_data;
    assign o_last           = out_res.last;

endmodule

`default_nettype wire
